@@ sv/gvfm_pkg.sv @@
// gvfm_pkg: shared constants, codes and types of the greedy voxel face mesher
// no dependencies

package gvfm_pkg;

  localparam int SIZE_X_DEF = 16;
  localparam int SIZE_Y_DEF = 16;
  localparam int SIZE_Z_DEF = 16;

  localparam int SZ_W    = 7;
  localparam int COORD_W = 22;
  localparam int Y_W     = 5;
  localparam int MAT_W   = 8;
  localparam int CHUNK_W = 17;
  localparam int CFG_IW  = 1;
  localparam int VOX_W   = 4;

  localparam logic [CFG_IW-1:0] REG_CHUNK_X = 1'd0;
  localparam logic [CFG_IW-1:0] REG_CHUNK_Z = 1'd1;

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_END = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FACE  = 1'b1;

  typedef struct packed {
    logic [1:0]       axis;
    logic [SZ_W-1:0]  plane;
    logic [SZ_W-1:0]  u;
    logic [SZ_W-1:0]  v;
    logic [SZ_W-1:0]  rw;
    logic [SZ_W-1:0]  rh;
    logic [MAT_W-1:0] mat;
  } rect_t;

  typedef struct packed {
    logic load;
    logic done;
  } coord_ctl_t;

endpackage

@@ sv/gvfm_if.sv @@
// gvfm_if: request, response and configuration channel interfaces
// depends on gvfm_pkg

interface gvfm_in_if import gvfm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [VOX_W-1:0] voxel_x;
  logic [VOX_W-1:0] voxel_y;
  logic [VOX_W-1:0] voxel_z;
  logic [MAT_W-1:0] voxel_material;
  modport source (output valid, cmd, voxel_x, voxel_y, voxel_z, voxel_material, input ready);
  modport sink (input valid, cmd, voxel_x, voxel_y, voxel_z, voxel_material, output ready);
endinterface

interface gvfm_out_if import gvfm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      done_res;
  logic [1:0]                face_axis;
  logic signed [COORD_W-1:0] x_lo;
  logic signed [COORD_W-1:0] x_hi;
  logic [Y_W-1:0]            y_lo;
  logic [Y_W-1:0]            y_hi;
  logic signed [COORD_W-1:0] z_lo;
  logic signed [COORD_W-1:0] z_hi;
  logic [MAT_W-1:0]          face_material;
  modport source (output valid, done_res, face_axis, x_lo, x_hi, y_lo, y_hi, z_lo, z_hi,
                  face_material, input ready);
  modport sink (input valid, done_res, face_axis, x_lo, x_hi, y_lo, y_hi, z_lo, z_hi,
                face_material, output ready);
endinterface

interface gvfm_cfg_if import gvfm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_IW-1:0]  index;
  logic [CHUNK_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/gvfm_ram.sv @@
// gvfm_ram: generic single-port ram with registered read
// no dependencies

module gvfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/gvfm_coord.sv @@
// gvfm_coord: turns a merged rectangle into world coordinates, holds the response payload
// depends on gvfm_pkg

module gvfm_coord import gvfm_pkg::*; #(
  parameter int SIZE_X = SIZE_X_DEF,
  parameter int SIZE_Z = SIZE_Z_DEF
) (
  input  logic                      clk,
  input  coord_ctl_t                ctl,
  input  rect_t                     rect,
  input  logic [CHUNK_W-1:0]        chunk_x,
  input  logic [CHUNK_W-1:0]        chunk_z,
  output logic                      done_res,
  output logic [1:0]                face_axis,
  output logic signed [COORD_W-1:0] x_lo,
  output logic signed [COORD_W-1:0] x_hi,
  output logic [Y_W-1:0]            y_lo,
  output logic [Y_W-1:0]            y_hi,
  output logic signed [COORD_W-1:0] z_lo,
  output logic signed [COORD_W-1:0] z_hi,
  output logic [MAT_W-1:0]          face_material
);

  localparam int EW = 24;

  logic signed [EW-1:0] cx_ext, cz_ext, ox, oz;
  logic [EW-1:0] pe, ue, ve, u_end, v_end;
  logic [EW-1:0] xl, xh, yl, yh, zl, zh;

  always_comb begin
    cx_ext = EW'(signed'(chunk_x));
    cz_ext = EW'(signed'(chunk_z));
    ox = cx_ext * signed'(EW'(SIZE_X));
    oz = cz_ext * signed'(EW'(SIZE_Z));
    pe = EW'(rect.plane);
    ue = EW'(rect.u);
    ve = EW'(rect.v);
    u_end = ue + EW'(rect.rw);
    v_end = ve + EW'(rect.rh);
    unique case (rect.axis)
      AXIS_X: begin
        xl = ox + pe; xh = ox + pe;
        yl = ue; yh = u_end;
        zl = oz + ve; zh = oz + v_end;
      end
      AXIS_Y: begin
        xl = ox + ue; xh = ox + u_end;
        yl = pe; yh = pe;
        zl = oz + ve; zh = oz + v_end;
      end
      default: begin
        xl = ox + ue; xh = ox + u_end;
        yl = ve; yh = v_end;
        zl = oz + pe; zh = oz + pe;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.done) begin
        done_res <= 1'b1;
        face_axis <= '0;
        x_lo <= '0; x_hi <= '0;
        y_lo <= '0; y_hi <= '0;
        z_lo <= '0; z_hi <= '0;
        face_material <= '0;
      end else begin
        done_res <= 1'b0;
        face_axis <= rect.axis;
        x_lo <= xl[COORD_W-1:0]; x_hi <= xh[COORD_W-1:0];
        y_lo <= yl[Y_W-1:0]; y_hi <= yh[Y_W-1:0];
        z_lo <= zl[COORD_W-1:0]; z_hi <= zh[COORD_W-1:0];
        face_material <= rect.mat;
      end
    end
  end

endmodule

@@ sv/greedy_voxel_face_mesher.sv @@
// greedy_voxel_face_mesher: top level, scan sequencer over voxel and plane mask rams
// depends on gvfm_pkg, gvfm_if, gvfm_ram, gvfm_coord
//
//   channel  role    transaction
//   req      sink    cmd 0 writes one voxel, cmd 1 asks for the next face rectangle
//   rsp      source  one rectangle or done per cmd 1 request
//   cfg      sink    chunk_x (index 0) or chunk_z (index 1)
//
// a voxel write is taken in the idle state; a request rebuilds the mask of a plane cell by
// cell, scans and probes its cells, clears merged cells, and may sweep all 51 planes
// after reset a clearing pass zeroes all SIZE_X*SIZE_Y*SIZE_Z voxel ram entries (each size
// power-of-two rounded, 4096 at default); req is not ready meanwhile, cfg always is
// req is ready only while idle; a finished result waits in the output register and a
// following request stalls only at its own end until rsp takes the previous one

module greedy_voxel_face_mesher import gvfm_pkg::*; #(
  parameter int SIZE_X = SIZE_X_DEF,
  parameter int SIZE_Y = SIZE_Y_DEF,
  parameter int SIZE_Z = SIZE_Z_DEF
) (
  input logic       clk,
  input logic       rst,
  gvfm_in_if.sink   req,
  gvfm_out_if.source rsp,
  gvfm_cfg_if.sink  cfg
);

  localparam int XW = $clog2(SIZE_X);
  localparam int YW = $clog2(SIZE_Y);
  localparam int ZW = $clog2(SIZE_Z);
  localparam int UW = (XW > YW) ? XW : YW;
  localparam int VW = (YW > ZW) ? YW : ZW;
  localparam int VAW = XW + YW + ZW;
  localparam int MAW = UW + VW;
  localparam int VDEPTH = 1 << VAW;
  localparam int MDEPTH = 1 << MAW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_BA, S_BB, S_BW, S_SRD, S_SCHK,
    S_ADV, S_RRD, S_RCHK, S_DINIT, S_DRD, S_DCHK, S_CLR, S_OUT
  } state_t;

  state_t state;
  logic [VAW-1:0] clr_addr;
  logic [1:0] axis;
  logic [SZ_W-1:0] plane;
  logic [UW-1:0] u, k;
  logic [VW-1:0] v, b_row;
  logic [UW:0] rw;
  logic [VW:0] rh;
  logic built, cell_end, done_flag, out_valid;
  logic [MAT_W-1:0] a_val, mat;
  logic [CHUNK_W-1:0] chunk_x, chunk_z;
  rect_t rect;

  logic [UW-1:0] w_last;
  logic [VW-1:0] h_last;
  logic [SZ_W-1:0] plane_last, pp, wx, wy, wz;
  logic a_ok, b_ok, in_range, req_fire, cfg_fire, out_free;
  logic vox_we, msk_we;
  logic [VAW-1:0] vox_addr, build_addr;
  logic [MAT_W-1:0] vox_wdata, vox_rdata, b_val;
  logic [MAW-1:0] msk_addr;
  logic [MAT_W-1:0] msk_wdata, msk_rdata;
  coord_ctl_t coord_ctl;

  function automatic logic [VAW-1:0] vaddr(input logic [SZ_W-1:0] x, y, z);
    return {y[YW-1:0], z[ZW-1:0], x[XW-1:0]};
  endfunction

  assign req.ready = (state == S_IDLE);
  assign req_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign out_free = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_comb begin
    w_last = (axis == AXIS_X) ? UW'(SIZE_Y - 1) : UW'(SIZE_X - 1);
    h_last = (axis == AXIS_Z) ? VW'(SIZE_Y - 1) : VW'(SIZE_Z - 1);
    unique case (axis)
      AXIS_X:  plane_last = SZ_W'(SIZE_X);
      AXIS_Y:  plane_last = SZ_W'(SIZE_Y);
      default: plane_last = SZ_W'(SIZE_Z);
    endcase
    a_ok = (plane != plane_last);
    b_ok = (plane != '0);
    pp = (state == S_BA) ? plane : plane - SZ_W'(1);
    unique case (axis)
      AXIS_X:  build_addr = vaddr(pp, SZ_W'(u), SZ_W'(v));
      AXIS_Y:  build_addr = vaddr(SZ_W'(u), pp, SZ_W'(v));
      default: build_addr = vaddr(SZ_W'(u), SZ_W'(v), pp);
    endcase
    wx = SZ_W'(req.voxel_x);
    wy = SZ_W'(req.voxel_y);
    wz = SZ_W'(req.voxel_z);
    in_range = (wx < SZ_W'(SIZE_X)) && (wy < SZ_W'(SIZE_Y)) && (wz < SZ_W'(SIZE_Z));
    b_val = b_ok ? vox_rdata : '0;
  end

  always_comb begin
    vox_we = 1'b0;
    vox_wdata = req.voxel_material;
    vox_addr = build_addr;
    if (state == S_CLEAR) begin
      vox_we = 1'b1;
      vox_wdata = '0;
      vox_addr = clr_addr;
    end else if (state == S_IDLE) begin
      vox_we = req_fire && (req.cmd == CMD_WRITE) && in_range;
      vox_addr = vaddr(wx, wy, wz);
    end
  end

  always_comb begin
    msk_we = 1'b0;
    msk_wdata = '0;
    unique case (state)
      S_RRD: msk_addr = {v, u + UW'(rw)};
      S_DRD: msk_addr = {v + VW'(rh), u + k};
      S_CLR: begin
        msk_addr = {v + b_row, u + k};
        msk_we = 1'b1;
      end
      S_BW: begin
        msk_addr = {v, u};
        msk_we = 1'b1;
        msk_wdata = (a_val != '0 && b_val == '0) ? a_val : '0;
      end
      default: msk_addr = {v, u};
    endcase
  end

  assign coord_ctl.load = (state == S_OUT) && out_free;
  assign coord_ctl.done = done_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      axis <= AXIS_X;
      plane <= '0;
      u <= '0;
      v <= '0;
      built <= 1'b0;
      cell_end <= 1'b0;
      done_flag <= 1'b0;
      out_valid <= 1'b0;
      chunk_x <= '0;
      chunk_z <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg.index)
          REG_CHUNK_X: chunk_x <= cfg.data;
          REG_CHUNK_Z: chunk_z <= cfg.data;
          default: ;
        endcase
      end
      if (out_valid && rsp.ready && !coord_ctl.load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + VAW'(1);
          if (clr_addr == VAW'(VDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            if (req.cmd == CMD_WRITE) begin
              axis <= AXIS_X;
              plane <= '0;
              u <= '0;
              v <= '0;
              built <= 1'b0;
              cell_end <= 1'b0;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (axis == AXIS_END) begin
            done_flag <= 1'b1;
            axis <= AXIS_X;
            plane <= '0;
            u <= '0;
            v <= '0;
            built <= 1'b0;
            cell_end <= 1'b0;
            state <= S_OUT;
          end else if (!built) begin
            u <= '0;
            v <= '0;
            state <= S_BA;
          end else begin
            state <= S_SRD;
          end
        end
        S_BA: state <= S_BB;
        S_BB: begin
          a_val <= a_ok ? vox_rdata : '0;
          state <= S_BW;
        end
        S_BW: begin
          if (u == w_last) begin
            u <= '0;
            if (v == h_last) begin
              v <= '0;
              built <= 1'b1;
              cell_end <= 1'b0;
              state <= S_SRD;
            end else begin
              v <= v + VW'(1);
              state <= S_BA;
            end
          end else begin
            u <= u + UW'(1);
            state <= S_BA;
          end
        end
        S_SRD: state <= cell_end ? S_ADV : S_SCHK;
        S_SCHK: begin
          if (msk_rdata != '0) begin
            mat <= msk_rdata;
            rw <= (UW+1)'(1);
            state <= (u == w_last) ? S_DINIT : S_RRD;
          end else if (u == w_last && v == h_last) begin
            state <= S_ADV;
          end else begin
            if (u == w_last) begin
              u <= '0;
              v <= v + VW'(1);
            end else begin
              u <= u + UW'(1);
            end
            state <= S_SRD;
          end
        end
        S_ADV: begin
          built <= 1'b0;
          cell_end <= 1'b0;
          u <= '0;
          v <= '0;
          if (plane >= plane_last) begin
            plane <= '0;
            axis <= axis + 2'd1;
          end else begin
            plane <= plane + SZ_W'(1);
          end
          state <= S_CHECK;
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: begin
          if (msk_rdata == mat) begin
            rw <= rw + (UW+1)'(1);
            state <= (({1'b0, u} + rw) < {1'b0, w_last}) ? S_RRD : S_DINIT;
          end else begin
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          rh <= (VW+1)'(1);
          k <= '0;
          b_row <= '0;
          state <= (v == h_last) ? S_CLR : S_DRD;
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          if (msk_rdata != mat) begin
            k <= '0;
            b_row <= '0;
            state <= S_CLR;
          end else if (k == UW'(rw - (UW+1)'(1))) begin
            rh <= rh + (VW+1)'(1);
            k <= '0;
            b_row <= '0;
            state <= (({1'b0, v} + rh) < {1'b0, h_last}) ? S_DRD : S_CLR;
          end else begin
            k <= k + UW'(1);
            state <= S_DRD;
          end
        end
        S_CLR: begin
          if (k == UW'(rw - (UW+1)'(1))) begin
            k <= '0;
            if (b_row == VW'(rh - (VW+1)'(1))) begin
              rect <= '{axis: axis, plane: plane, u: SZ_W'(u), v: SZ_W'(v),
                        rw: SZ_W'(rw), rh: SZ_W'(rh), mat: mat};
              done_flag <= 1'b0;
              if (u == w_last) begin
                if (v == h_last) begin
                  cell_end <= 1'b1;
                end else begin
                  u <= '0;
                  v <= v + VW'(1);
                end
              end else begin
                u <= u + UW'(1);
              end
              state <= S_OUT;
            end else begin
              b_row <= b_row + VW'(1);
            end
          end else begin
            k <= k + UW'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gvfm_ram #(.WIDTH(MAT_W), .DEPTH(VDEPTH)) u_vox_ram (
    .clk(clk), .we(vox_we), .addr(vox_addr), .wdata(vox_wdata), .rdata(vox_rdata)
  );

  gvfm_ram #(.WIDTH(MAT_W), .DEPTH(MDEPTH)) u_mask_ram (
    .clk(clk), .we(msk_we), .addr(msk_addr), .wdata(msk_wdata), .rdata(msk_rdata)
  );

  gvfm_coord #(.SIZE_X(SIZE_X), .SIZE_Z(SIZE_Z)) u_coord (
    .clk(clk), .ctl(coord_ctl), .rect(rect), .chunk_x(chunk_x), .chunk_z(chunk_z),
    .done_res(rsp.done_res), .face_axis(rsp.face_axis),
    .x_lo(rsp.x_lo), .x_hi(rsp.x_hi), .y_lo(rsp.y_lo), .y_hi(rsp.y_hi),
    .z_lo(rsp.z_lo), .z_hi(rsp.z_hi), .face_material(rsp.face_material)
  );

endmodule

@@ sv/gvfm_chk.sv @@
// gvfm_chk: port-level assertions of the greedy voxel face mesher, with its bind
// depends on gvfm_pkg and the top level greedy_voxel_face_mesher

module gvfm_chk import gvfm_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      done_res,
  input logic [1:0]                face_axis,
  input logic signed [COORD_W-1:0] x_lo,
  input logic signed [COORD_W-1:0] x_hi,
  input logic [Y_W-1:0]            y_lo,
  input logic [Y_W-1:0]            y_hi,
  input logic signed [COORD_W-1:0] z_lo,
  input logic signed [COORD_W-1:0] z_hi,
  input logic [MAT_W-1:0]          face_material
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !req_ready && !rsp_valid)
    else $error("req ready or rsp valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_lo) && $stable(z_hi)
      && $stable(face_material) && $stable(done_res))
    else $error("stalled response changed");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && done_res |-> face_axis == '0 && x_lo == '0 && x_hi == '0 && y_lo == '0
      && y_hi == '0 && z_lo == '0 && z_hi == '0 && face_material == '0)
    else $error("done response carries a rectangle");

  a_flat_face: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !done_res |-> (face_axis == AXIS_X && x_lo == x_hi)
      || (face_axis == AXIS_Y && y_lo == y_hi) || (face_axis == AXIS_Z && z_lo == z_hi))
    else $error("face not flat along its normal axis");

endmodule

bind greedy_voxel_face_mesher gvfm_chk u_gvfm_chk (
  .clk(clk), .rst(rst), .req_ready(req.ready), .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready), .done_res(rsp.done_res), .face_axis(rsp.face_axis),
  .x_lo(rsp.x_lo), .x_hi(rsp.x_hi), .y_lo(rsp.y_lo), .y_hi(rsp.y_hi),
  .z_lo(rsp.z_lo), .z_hi(rsp.z_hi), .face_material(rsp.face_material)
);

@@ verif/tb_greedy_voxel_face_mesher.sv @@
// tb_greedy_voxel_face_mesher: self-checking testbench of the greedy voxel face mesher
// depends on gvfm_pkg, gvfm_if and the greedy_voxel_face_mesher rtl

module tb_greedy_voxel_face_mesher;
  import gvfm_pkg::*;

  typedef struct packed {
    logic                      done;
    logic [1:0]                axis;
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] x_hi;
    logic [Y_W-1:0]            y_lo;
    logic [Y_W-1:0]            y_hi;
    logic signed [COORD_W-1:0] z_lo;
    logic signed [COORD_W-1:0] z_hi;
    logic [MAT_W-1:0]          mat;
  } face_t;

  typedef struct {
    logic  cmd;
    int    x;
    int    y;
    int    z;
    int    m;
    bit    typed;
    face_t exp;
  } row_t;

  localparam int NX = SIZE_X_DEF;
  localparam int NY = SIZE_Y_DEF;
  localparam int NZ = SIZE_Z_DEF;
  localparam int ITEMS = 1170;

  logic clk = 1'b0;
  logic rst;

  gvfm_in_if  req_if();
  gvfm_out_if rsp_if();
  gvfm_cfg_if cfg_if();

  greedy_voxel_face_mesher uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  // mesher state mirror
  logic [MAT_W-1:0]          vox [NX*NY*NZ];
  logic [MAT_W-1:0]          mask [256];
  int                        scan_ax;
  int                        scan_pl;
  int                        scan_c;
  bit                        built;
  logic signed [CHUNK_W-1:0] chunk_x;
  logic signed [CHUNK_W-1:0] chunk_z;

  face_t rect_q[$];
  int    errors = 0;
  int    resp_cnt = 0;
  int    sent = 0;
  bit    no_idle = 0;
  face_t last_face;

  function automatic logic [MAT_W-1:0] voxel_at(int x, int y, int z);
    if (x < 0 || x >= NX || y < 0 || y >= NY || z < 0 || z >= NZ) return '0;
    return vox[x + NX * (z + NZ * y)];
  endfunction

  function automatic int row_w(int ax);
    return ax == AXIS_X ? NY : NX;
  endfunction

  function automatic int col_h(int ax);
    return ax == AXIS_Z ? NY : NZ;
  endfunction

  function automatic void build_plane_mask();
    int w;
    int h;
    logic [MAT_W-1:0] a;
    logic [MAT_W-1:0] b;
    w = row_w(scan_ax);
    h = col_h(scan_ax);
    for (int v = 0; v < h; v++) begin
      for (int u = 0; u < w; u++) begin
        if (scan_ax == AXIS_X) begin
          a = voxel_at(scan_pl, u, v); b = voxel_at(scan_pl - 1, u, v);
        end else if (scan_ax == AXIS_Y) begin
          a = voxel_at(u, scan_pl, v); b = voxel_at(u, scan_pl - 1, v);
        end else begin
          a = voxel_at(u, v, scan_pl); b = voxel_at(u, v, scan_pl - 1);
        end
        mask[u + w * v] = (a != 0 && b == 0) ? a : '0;
      end
    end
    scan_c = 0;
    built = 1;
  endfunction

  function automatic void rewind();
    scan_ax = 0;
    scan_pl = 0;
    scan_c = 0;
    built = 0;
  endfunction

  function automatic void reset_mirror();
    foreach (vox[i]) vox[i] = '0;
    rewind();
    chunk_x = '0;
    chunk_z = '0;
  endfunction

  // next merged rectangle, or done when the scan is exhausted
  function automatic face_t next_face();
    face_t r;
    int w, h, u, v, rw, rh, ox, oz, last;
    bit ok;
    logic [MAT_W-1:0] m;
    r = '0;
    forever begin
      if (scan_ax > 2) begin
        r.done = 1'b1;
        rewind();
        return r;
      end
      if (!built) build_plane_mask();
      w = row_w(scan_ax);
      h = col_h(scan_ax);
      while (scan_c < w * h && mask[scan_c] == 0) scan_c++;
      if (scan_c < w * h) begin
        u = scan_c % w;
        v = scan_c / w;
        m = mask[scan_c];
        rw = 1;
        rh = 1;
        while (u + rw < w && mask[u + rw + v * w] == m) rw++;
        ok = 1;
        while (ok && v + rh < h) begin
          for (int k = 0; k < rw; k++)
            if (mask[u + k + (v + rh) * w] != m) ok = 0;
          if (ok) rh++;
        end
        for (int j = 0; j < rh; j++)
          for (int i = 0; i < rw; i++) mask[u + i + (v + j) * w] = '0;
        scan_c++;
        ox = int'(chunk_x) * NX;
        oz = int'(chunk_z) * NZ;
        r.axis = scan_ax[1:0];
        r.mat = m;
        if (scan_ax == AXIS_X) begin
          r.x_lo = COORD_W'(ox + scan_pl); r.x_hi = COORD_W'(ox + scan_pl);
          r.y_lo = Y_W'(u); r.y_hi = Y_W'(u + rw);
          r.z_lo = COORD_W'(oz + v); r.z_hi = COORD_W'(oz + v + rh);
        end else if (scan_ax == AXIS_Y) begin
          r.x_lo = COORD_W'(ox + u); r.x_hi = COORD_W'(ox + u + rw);
          r.y_lo = Y_W'(scan_pl); r.y_hi = Y_W'(scan_pl);
          r.z_lo = COORD_W'(oz + v); r.z_hi = COORD_W'(oz + v + rh);
        end else begin
          r.x_lo = COORD_W'(ox + u); r.x_hi = COORD_W'(ox + u + rw);
          r.y_lo = Y_W'(v); r.y_hi = Y_W'(v + rh);
          r.z_lo = COORD_W'(oz + scan_pl); r.z_hi = COORD_W'(oz + scan_pl);
        end
        return r;
      end
      built = 0;
      scan_c = 0;
      last = scan_ax == AXIS_X ? NX : (scan_ax == AXIS_Y ? NY : NZ);
      if (scan_pl >= last) begin
        scan_pl = 0;
        scan_ax++;
      end else begin
        scan_pl++;
      end
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send_req(logic cmd, int x, int y, int z, int m, bit typed, face_t exp);
    int gap;
    face_t f;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.voxel_x <= VOX_W'(x);
    req_if.voxel_y <= VOX_W'(y);
    req_if.voxel_z <= VOX_W'(z);
    req_if.voxel_material <= MAT_W'(m);
    do @(posedge clk); while (!req_if.ready);
    sent++;
    if (cmd == CMD_WRITE) begin
      vox[x + NX * (z + NZ * y)] = MAT_W'(m);
      rewind();
    end else begin
      f = next_face();
      last_face = f;
      rect_q.insert(rect_q.size(), typed ? exp : f);
    end
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CHUNK_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_CHUNK_X) chunk_x = val;
    else chunk_z = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (rect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void check_face(face_t e, face_t a);
    if (a.done !== e.done) begin
      $error("done_res: expected %0d actual %0d", e.done, a.done); errors++;
    end
    if (a.axis !== e.axis) begin
      $error("face_axis: expected %0d actual %0d", e.axis, a.axis); errors++;
    end
    if (a.x_lo !== e.x_lo) begin
      $error("x_lo: expected %0d actual %0d", e.x_lo, a.x_lo); errors++;
    end
    if (a.x_hi !== e.x_hi) begin
      $error("x_hi: expected %0d actual %0d", e.x_hi, a.x_hi); errors++;
    end
    if (a.y_lo !== e.y_lo) begin
      $error("y_lo: expected %0d actual %0d", e.y_lo, a.y_lo); errors++;
    end
    if (a.y_hi !== e.y_hi) begin
      $error("y_hi: expected %0d actual %0d", e.y_hi, a.y_hi); errors++;
    end
    if (a.z_lo !== e.z_lo) begin
      $error("z_lo: expected %0d actual %0d", e.z_lo, a.z_lo); errors++;
    end
    if (a.z_hi !== e.z_hi) begin
      $error("z_hi: expected %0d actual %0d", e.z_hi, a.z_hi); errors++;
    end
    if (a.mat !== e.mat) begin
      $error("face_material: expected %0d actual %0d", e.mat, a.mat); errors++;
    end
  endfunction

  // response side
  initial begin
    int gap;
    face_t act;
    rsp_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = (resp_cnt == 40) ? 1500 : draw_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      act = '{rsp_if.done_res, rsp_if.face_axis, rsp_if.x_lo, rsp_if.x_hi, rsp_if.y_lo,
              rsp_if.y_hi, rsp_if.z_lo, rsp_if.z_hi, rsp_if.face_material};
      resp_cnt++;
      if (rect_q.size() == 0) begin
        $error("unexpected response transaction");
        errors++;
      end else begin
        check_face(rect_q.pop_front(), act);
      end
    end
  end

  row_t dir_rows[] = '{
    '{CMD_FACE, 0, 0, 0, 0, 1, '{1'b1, 2'd0, 22'sd0, 22'sd0, 5'd0, 5'd0, 22'sd0, 22'sd0, 8'd0}},
    '{CMD_WRITE, 0, 0, 0, 255, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 1, '{1'b0, AXIS_X, -22'sd1048576, -22'sd1048576, 5'd0, 5'd1,
                                 22'sd1048560, 22'sd1048561, 8'd255}},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_WRITE, 15, 15, 15, 1, 0, '0},
    '{CMD_WRITE, 1, 0, 0, 255, 0, '0},
    '{CMD_WRITE, 0, 1, 0, 255, 0, '0},
    '{CMD_WRITE, 7, 8, 9, 128, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_WRITE, 15, 15, 15, 0, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_WRITE, 8, 7, 6, 127, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0},
    '{CMD_FACE, 0, 0, 0, 0, 0, '0}
  };

  // request side
  initial begin
    int n, lim, phase;
    logic [MAT_W-1:0] mats[3];
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_WRITE;
    req_if.voxel_x = '0;
    req_if.voxel_y = '0;
    req_if.voxel_z = '0;
    req_if.voxel_material = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CHUNK_X;
    cfg_if.data = '0;
    reset_mirror();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_CHUNK_X, 17'h10000);
    write_reg(REG_CHUNK_Z, 17'h0ffff);
    foreach (dir_rows[i])
      send_req(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].m,
               dir_rows[i].typed, dir_rows[i].exp);
    phase = 0;
    while (sent < ITEMS) begin
      req_if.valid <= 1'b0;
      wait_idle();
      case (phase % 4)
        0: begin
          write_reg(REG_CHUNK_X, 17'h0ffff); write_reg(REG_CHUNK_Z, 17'h10000);
        end
        1: begin
          write_reg(REG_CHUNK_X, '0); write_reg(REG_CHUNK_Z, '0);
        end
        default: begin
          write_reg(REG_CHUNK_X, CHUNK_W'($urandom_range(0, 131071)));
          write_reg(REG_CHUNK_Z, CHUNK_W'($urandom_range(0, 131071)));
        end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      foreach (mats[i]) mats[i] = MAT_W'($urandom_range(1, 255));
      lim = ($urandom_range(0, 3) == 0) ? 15 : 3;
      n = $urandom_range(30, 60);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0)
          send_req(CMD_FACE, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 255), 0, '0);
        else
          send_req(CMD_WRITE, $urandom_range(0, lim), $urandom_range(0, lim),
                   $urandom_range(0, lim),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : int'(mats[$urandom_range(0, 2)]), 0, '0);
      end
      // walk the whole scan to its end
      do send_req(CMD_FACE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 255), 0, '0);
      while (!last_face.done);
      phase++;
    end
    req_if.valid <= 1'b0;
    while (rect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #1000000000;
    $display("FAIL");
    $finish;
  end

endmodule
